/* design/keyboard_report_key_event_diff_defines.svh */
// Assertion macros shared by the key event diff block.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef KEYBOARD_REPORT_KEY_EVENT_DIFF_DEFINES_SVH
`define KEYBOARD_REPORT_KEY_EVENT_DIFF_DEFINES_SVH

// same-cycle implication
`define KBDIFF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KBDIFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/kbdiff_pkg.sv */
// Types and constants for the keyboard report key event diff block.
// No dependencies.
`timescale 1ns / 1ps
package kbdiff_pkg;

  localparam int KEY_SLOTS      = 6;
  localparam int MIN_REPORT_LEN = 8;
  localparam int EVENT_LANES    = 2 * KEY_SLOTS;
  localparam int LANE_IDX_W     = $clog2(EVENT_LANES);

  localparam logic EV_RELEASE = 1'b0;
  localparam logic EV_PRESS   = 1'b1;

  typedef logic [7:0] key_code_t;

  typedef struct packed {
    logic [6:0] report_length;
    logic [7:0] modifier_bits;
    logic [7:0] key_0;
    logic [7:0] key_1;
    logic [7:0] key_2;
    logic [7:0] key_3;
    logic [7:0] key_4;
    logic [7:0] key_5;
  } in_t;

  typedef struct packed {
    logic       event_kind;
    logic [7:0] event_key;
    logic [7:0] event_modifiers;
    logic       last_event;
  } out_t;

  // lane results handed to the merge stage
  typedef struct packed {
    logic                   load;
    logic [EVENT_LANES-1:0] hit;
  } batch_t;

endpackage

/* design/kbdiff_lane.sv */
// One compare lane: flags a nonzero code that is missing from a slot set.
// Depends on kbdiff_pkg.
`timescale 1ns / 1ps
module kbdiff_lane #(
  parameter int SLOTS = kbdiff_pkg::KEY_SLOTS
) (
  input  kbdiff_pkg::key_code_t             code,
  input  kbdiff_pkg::key_code_t [SLOTS-1:0] slots,
  output logic                              hit
);
  import kbdiff_pkg::*;

  logic found;

  always_comb begin
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slots[i] == code) begin
        found = 1'b1;
      end
    end
    hit = (code != '0) && !found;
  end

endmodule

/* design/kbdiff_merge.sv */
// Merge stage: holds the lane hits of one report and sends them out one
// beat at a time, releases first, through an output register.
// Depends on kbdiff_pkg and the defines header.
`timescale 1ns / 1ps
`include "keyboard_report_key_event_diff_defines.svh"
module kbdiff_merge (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  kbdiff_pkg::batch_t                                batch,
  input  kbdiff_pkg::key_code_t [kbdiff_pkg::EVENT_LANES-1:0] codes,
  input  logic [7:0]                                        rel_mods,
  input  logic [7:0]                                        prs_mods,
  output logic                                              idle,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output kbdiff_pkg::out_t                                  out_data
);
  import kbdiff_pkg::*;

  logic [EVENT_LANES-1:0] pending_r, pending_nxt;
  key_code_t [EVENT_LANES-1:0] codes_r;
  logic [7:0]             rel_mods_r, prs_mods_r;
  logic                   out_valid_r, out_valid_nxt;
  out_t                   out_data_r, out_data_nxt;

  logic [LANE_IDX_W-1:0]  pick;
  logic                   found;
  logic [EVENT_LANES-1:0] rest;
  logic                   adv;

  assign idle = (pending_r == '0);
  assign adv  = !idle && (!out_valid_r || out_ready);

  // lowest pending lane wins
  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int i = 0; i < EVENT_LANES; i++) begin
      if (pending_r[i] && !found) begin
        pick  = LANE_IDX_W'(i);
        found = 1'b1;
      end
    end
    rest       = pending_r;
    rest[pick] = 1'b0;
  end

  always_comb begin
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv) begin
      pending_nxt                  = rest;
      out_valid_nxt                = 1'b1;
      out_data_nxt.event_kind      = (pick >= LANE_IDX_W'(KEY_SLOTS)) ? EV_PRESS : EV_RELEASE;
      out_data_nxt.event_key       = codes_r[pick];
      out_data_nxt.event_modifiers =
        (pick >= LANE_IDX_W'(KEY_SLOTS)) ? prs_mods_r : rel_mods_r;
      out_data_nxt.last_event      = (rest == '0);
    end
    if (batch.load) begin
      pending_nxt = batch.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (batch.load) begin
      codes_r    <= codes;
      rel_mods_r <= rel_mods;
      prs_mods_r <= prs_mods;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `KBDIFF_ASSERT_NOW(a_load_when_idle, batch.load, pending_r == '0, "batch loaded over pending events")
  `KBDIFF_ASSERT_NEXT(a_one_per_beat, adv,
    $countones(pending_r) == $past($countones(pending_r)) - 1, "pending events not retired one at a time")
  `KBDIFF_ASSERT_NEXT(a_last_drains, adv && (rest == '0),
    out_valid_r && out_data_r.last_event && (pending_r == '0), "last event flag out of step")

endmodule

/* design/keyboard_report_key_event_diff.sv */
// Keyboard boot report key event diff, top level.
// On accept, the lane hits are registered as pending events; the merge stage then moves
// them into the output register one event per cycle while out_ready does not stall it, and
// the next report is taken once the previous one's last event is in the output register.
// Twelve compare lanes work in parallel at accept; the merge stage sets the event rate.
// Reset (rst_n, synchronous): held keys and modifiers zero, no events pending.
`timescale 1ns / 1ps
module keyboard_report_key_event_diff (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  kbdiff_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output kbdiff_pkg::out_t out_data
);
  import kbdiff_pkg::*;

  key_code_t [KEY_SLOTS-1:0]   held_keys_r, held_keys_nxt;
  logic [7:0]                  held_mods_r, held_mods_nxt;
  key_code_t [KEY_SLOTS-1:0]   fresh;
  key_code_t [EVENT_LANES-1:0] codes;
  logic [EVENT_LANES-1:0]      hit;
  logic                        take;
  logic                        idle;
  batch_t                      batch;

  assign fresh = {in_data.key_5, in_data.key_4, in_data.key_3,
                  in_data.key_2, in_data.key_1, in_data.key_0};

  assign in_ready = idle;
  assign take     = in_valid && in_ready &&
                    (in_data.report_length >= 7'(MIN_REPORT_LEN));

  // lanes 0..5 look for releases, 6..11 for presses
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    kbdiff_lane #(.SLOTS(KEY_SLOTS)) u_rel (
      .code  (held_keys_r[g]),
      .slots (fresh),
      .hit   (hit[g])
    );
    kbdiff_lane #(.SLOTS(KEY_SLOTS)) u_prs (
      .code  (fresh[g]),
      .slots (held_keys_r),
      .hit   (hit[KEY_SLOTS + g])
    );
    assign codes[g]             = held_keys_r[g];
    assign codes[KEY_SLOTS + g] = fresh[g];
  end

  assign batch.load = take;
  assign batch.hit  = hit;

  kbdiff_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .batch     (batch),
    .codes     (codes),
    .rel_mods  (held_mods_r),
    .prs_mods  (in_data.modifier_bits),
    .idle      (idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_comb begin
    held_keys_nxt = held_keys_r;
    held_mods_nxt = held_mods_r;
    if (take) begin
      held_keys_nxt = fresh;
      held_mods_nxt = in_data.modifier_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_keys_r <= '0;
      held_mods_r <= '0;
    end else begin
      held_keys_r <= held_keys_nxt;
      held_mods_r <= held_mods_nxt;
    end
  end

endmodule
